// ----- hdl/crlc_pkg.sv -----
// ----------------------------------------------------------------------------
// crlc_pkg
// Shared types and text constants for the line response classifier.
// ----------------------------------------------------------------------------
package crlc_pkg;

  localparam int unsigned BANNER_LEN = 17;
  localparam int unsigned PROG_W     = 5;
  localparam int unsigned NUM_EXACT  = 3;
  localparam int unsigned EXACT_MAX  = 16;
  localparam int unsigned CLASS_W    = 3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_BANNER   = 3'd0,
    CLASS_PRESSED  = 3'd1,
    CLASS_RELEASED = 3'd2,
    CLASS_WRONG    = 3'd3,
    CLASS_OTHER    = 3'd4
  } line_class_e;

  // reset banner text, no character repeats its first letter
  localparam logic [7:0] BANNER_TEXT [BANNER_LEN] = '{
    8'h57, 8'h65, 8'h6C, 8'h63, 8'h6F, 8'h6D, 8'h65, 8'h20, 8'h74,
    8'h6F, 8'h20, 8'h4E, 8'h75, 8'h63, 8'h6C, 8'h65, 8'h6F
  };

  // exact texts: button pressed, button released, wrong command
  localparam logic [7:0] EXACT_TEXT [NUM_EXACT][EXACT_MAX] = '{
    '{8'h42, 8'h55, 8'h54, 8'h54, 8'h4F, 8'h4E, 8'h3A, 8'h50,
      8'h52, 8'h45, 8'h53, 8'h53, 8'h45, 8'h44, 8'h00, 8'h00},
    '{8'h42, 8'h55, 8'h54, 8'h54, 8'h4F, 8'h4E, 8'h3A, 8'h52,
      8'h45, 8'h4C, 8'h45, 8'h41, 8'h53, 8'h45, 8'h44, 8'h00},
    '{8'h57, 8'h72, 8'h6F, 8'h6E, 8'h67, 8'h20, 8'h63, 8'h6F,
      8'h6D, 8'h6D, 8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] EXACT_LEN [NUM_EXACT] = '{4'd14, 4'd15, 4'd13};

  typedef struct packed {
    logic        valid;
    line_class_e line_class;
  } crlc_result_t;

endpackage

// ----- hdl/crlc_in_stage.sv -----
// ----------------------------------------------------------------------------
// crlc_in_stage
// Input register for received bytes, released when the core consumes a beat.
// ----------------------------------------------------------------------------
module crlc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- hdl/crlc_core.sv -----
// ----------------------------------------------------------------------------
// crlc_core
// Running line state: length, previous byte, banner and exact-text matching.
// ----------------------------------------------------------------------------
module crlc_core #(
  parameter int unsigned LINE_LIMIT = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output crlc_pkg::crlc_result_t result_o
);
  import crlc_pkg::*;

  localparam int unsigned LW = $clog2(LINE_LIMIT);
  localparam logic [LW-1:0] LAST_POS = LW'(LINE_LIMIT - 1);

  logic [LW-1:0]        len_q, len_d;
  logic [7:0]           prev_q;
  logic [PROG_W-1:0]    prog_q, prog_d;
  logic                 found_q, found_d;
  logic [NUM_EXACT-1:0] miss_q, miss_d;
  logic                 zero_q, zero_d;

  logic                 over, complete, feed;
  logic [7:0]           c;
  logic [LW-1:0]        bpos;
  logic [NUM_EXACT-1:0] miss_f;
  logic [PROG_W-1:0]    prog_f;
  logic                 found_f, zero_f;
  line_class_e          cls;

  assign over     = (len_q >= LAST_POS);
  assign complete = !over && (len_q != '0) && (prev_q == CHAR_CR) && (byte_i == CHAR_LF);
  assign feed     = !over && (len_q != '0);
  assign c        = complete ? 8'h00 : prev_q;
  assign bpos     = len_q - LW'(1);

  always_comb begin
    miss_f  = miss_q;
    prog_f  = prog_q;
    found_f = found_q;
    zero_f  = zero_q;
    if (feed && !zero_q) begin
      for (int i = 0; i < NUM_EXACT; i++) begin
        if (bpos < LW'(EXACT_LEN[i])) begin
          if (c != EXACT_TEXT[i][bpos[3:0]]) miss_f[i] = 1'b1;
        end else if (bpos == LW'(EXACT_LEN[i])) begin
          if (c != 8'h00) miss_f[i] = 1'b1;
        end else begin
          miss_f[i] = 1'b1;
        end
      end
      if (c == 8'h00) begin
        zero_f = 1'b1;
        prog_f = '0;
      end else if (!found_q) begin
        if (c == BANNER_TEXT[prog_q]) begin
          prog_f = prog_q + PROG_W'(1);
        end else if (c == BANNER_TEXT[0]) begin
          prog_f = PROG_W'(1);
        end else begin
          prog_f = '0;
        end
        if (prog_f == PROG_W'(BANNER_LEN)) begin
          found_f = 1'b1;
          prog_f  = '0;
        end
      end
    end
  end

  always_comb begin
    if (found_f) begin
      cls = CLASS_BANNER;
    end else if (!miss_f[0]) begin
      cls = CLASS_PRESSED;
    end else if (!miss_f[1]) begin
      cls = CLASS_RELEASED;
    end else if (!miss_f[2]) begin
      cls = CLASS_WRONG;
    end else begin
      cls = CLASS_OTHER;
    end
  end

  assign result_o.valid      = complete;
  assign result_o.line_class = cls;

  always_comb begin
    if (over || complete) begin
      len_d   = '0;
      prog_d  = '0;
      found_d = 1'b0;
      miss_d  = '0;
      zero_d  = 1'b0;
    end else begin
      len_d   = len_q + LW'(1);
      prog_d  = prog_f;
      found_d = found_f;
      miss_d  = miss_f;
      zero_d  = zero_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      prev_q  <= '0;
      prog_q  <= '0;
      found_q <= 1'b0;
      miss_q  <= '0;
      zero_q  <= 1'b0;
    end else if (step_i) begin
      len_q   <= len_d;
      prev_q  <= byte_i;
      prog_q  <= prog_d;
      found_q <= found_d;
      miss_q  <= miss_d;
      zero_q  <= zero_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LAST_POS)
    else $error("line length beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q < PROG_W'(BANNER_LEN))
    else $error("banner progress out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (result_o.valid || over) |=> (len_q == '0) && !found_q && (miss_q == '0))
    else $error("line state not cleared after line end");

endmodule

// ----- hdl/crlc_out_stage.sv -----
// ----------------------------------------------------------------------------
// crlc_out_stage
// Result register holding one class code until the receiver takes it.
// ----------------------------------------------------------------------------
module crlc_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  crlc_pkg::line_class_e  class_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             line_class_o
);
  import crlc_pkg::*;

  logic        valid_q, valid_d;
  line_class_e class_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      class_q <= class_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign line_class_o = class_q;

endmodule

// ----- hdl/crlf_line_response_classifier.sv -----
// ----------------------------------------------------------------------------
// crlf_line_response_classifier
// Classifies CR LF terminated lines received byte by byte.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o with rx_byte_i, one byte per beat.
// Output channel: out_valid_o / out_ready_i with line_class_o, one beat per
// completed line (0 banner, 1 pressed, 2 released, 3 wrong command, 4 other).
// Bytes that do not complete a line give no output beat; a line that reaches
// LINE_LIMIT bytes is dropped silently.
// Throughput: one byte per cycle unless a completed line waits on a full
// result register; the match update between the registers is combinational.
// The LF byte waits in the input register until the result register is free,
// then its class code is loaded there and shown with out_valid_o.
// Reset clears the line state, the previous byte and the valid flags of both registers.
// When the receiver stalls, a byte that would complete a line waits in the
// input register; bytes that complete nothing keep flowing, and input ready
// drops only once that waiting byte cannot move on.
// ----------------------------------------------------------------------------
module crlf_line_response_classifier #(
  parameter int unsigned LINE_LIMIT = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] line_class_o
);
  import crlc_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         step;
  logic         out_free;
  crlc_result_t res;

  crlc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  crlc_core #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte),
    .result_o (res)
  );

  assign step = s1_valid && (!res.valid || out_free);

  crlc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step && res.valid),
    .class_i      (res.line_class),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_class_o (line_class_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step && res.valid && out_valid_o && !out_ready_i))
    else $error("result loaded over a stalled beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid && res.valid)
    else $error("input stalled without a waiting line result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.valid |=> out_valid_o)
    else $error("line result lost");

endmodule
